// File: sv/camera_point_projection_assert.svh
// Assertion macros for the camera point projection block.
`ifndef CAMERA_POINT_PROJECTION_ASSERT_SVH
`define CAMERA_POINT_PROJECTION_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define CPP_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("camera_point_projection: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define CPP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("camera_point_projection: next-cycle check failed");

`endif

// File: sv/cpp_pkg.sv
// Shared types and constants of the camera point projection block.
`timescale 1ns / 1ps
`default_nettype none

package cpp_pkg;

  localparam int CMP_W         = 20;             // vector component width
  localparam int VEC_W         = 3 * CMP_W;      // packed x,y,z vector
  localparam int OUT_W         = 32;             // screen coordinate width
  localparam int QB_W          = OUT_W + 1;      // quotient bits resolved by the divider
  localparam int LIMB_W        = 24;             // multiplier limb width
  localparam int MUL_LAT       = 4;              // cpp_mul latency
  localparam int DIV_LAT       = QB_W + 2;       // cpp_div latency
  localparam int SENTINEL_VALUE = -10000;
  localparam int CFG_IDX_W     = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOCATION = 3'd0,
    CFG_NORMAL   = 3'd1,
    CFG_X_AXIS   = 3'd2,
    CFG_Y_AXIS   = 3'd3,
    CFG_FOCAL    = 3'd4
  } cpp_cfg_e;

  typedef struct packed {
    logic signed [CMP_W-1:0] point_x;
    logic signed [CMP_W-1:0] point_y;
    logic signed [CMP_W-1:0] point_z;
  } cpp_point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] screen_x;
    logic signed [OUT_W-1:0] screen_y;
    logic                    rejected;
  } cpp_screen_t;

endpackage

`default_nettype wire

// File: sv/cpp_mul.sv
// Pipelined signed multiplier built from narrow limb products.
`timescale 1ns / 1ps
`default_nettype none

module cpp_mul #(
  parameter int AW = 8,
  parameter int BW = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic signed [AW-1:0] a_i,
  input  wire logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0]   p_o
);
  import cpp_pkg::*;

  localparam int NA = (AW + LIMB_W - 1) / LIMB_W;
  localparam int NB = (BW + LIMB_W - 1) / LIMB_W;
  localparam int PW = AW + BW;

  logic [AW-1:0]        amag;
  logic [BW-1:0]        bmag;
  logic [NA*LIMB_W-1:0] am_q;
  logic [NB*LIMB_W-1:0] bm_q;
  logic                 ng1_q, ng2_q, ng3_q;
  logic [2*LIMB_W-1:0]  pp_q [NA*NB];
  logic [PW-1:0]        sum_d, sum_q;
  logic signed [PW-1:0] p_q;

  assign amag = a_i[AW-1] ? AW'(-a_i) : AW'(a_i);
  assign bmag = b_i[BW-1] ? BW'(-b_i) : BW'(b_i);

  // shift-add of the limb products
  always_comb begin
    sum_d = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum_d = sum_d + (PW'(pp_q[i*NB+j]) << (LIMB_W * (i + j)));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      am_q  <= (NA*LIMB_W)'(amag);
      bm_q  <= (NB*LIMB_W)'(bmag);
      ng1_q <= a_i[AW-1] ^ b_i[BW-1];
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i*NB+j] <= am_q[i*LIMB_W +: LIMB_W] * bm_q[j*LIMB_W +: LIMB_W];
        end
      end
      ng2_q <= ng1_q;
      sum_q <= sum_d;
      ng3_q <= ng2_q;
      p_q   <= ng3_q ? -$signed(sum_q) : $signed(sum_q);
    end
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: sv/cpp_div.sv
// Pipelined restoring divider with floor rounding and signed saturation.
`timescale 1ns / 1ps
`default_nettype none

module cpp_div #(
  parameter int NW = 16,
  parameter int DW = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     en_i,
  input  wire logic [NW-1:0]            mag_i,
  input  wire logic [DW-1:0]            div_i,
  input  wire logic                     neg_i,
  output logic signed [cpp_pkg::OUT_W-1:0] quot_o
);
  import cpp_pkg::*;

  localparam int XW = (NW > DW + QB_W) ? NW : DW + QB_W;
  localparam logic [QB_W:0]    NEG_LIM = (QB_W+1)'(1) << (OUT_W - 1);
  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  logic [XW-1:0]   rem_q [QB_W+1];
  logic [QB_W-1:0] q_q   [QB_W+1];
  logic [DW-1:0]   dv_q  [QB_W+1];
  logic            ng_q  [QB_W+1];
  logic            ov_q  [QB_W+1];
  logic [QB_W:0]   qq;
  logic [OUT_W-1:0] quot_d;
  logic [OUT_W-1:0] quot_q;

  // entry: quotient beyond QB_W bits always saturates
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= XW'(mag_i);
      q_q[0]   <= '0;
      dv_q[0]  <= div_i;
      ng_q[0]  <= neg_i;
      ov_q[0]  <= XW'(mag_i) >= (XW'(div_i) << QB_W);
    end
  end

  for (genvar k = 0; k < QB_W; k++) begin : g_step
    logic [XW:0] trial;
    assign trial = {1'b0, rem_q[k]} - ({1'b0, XW'(dv_q[k])} << (QB_W - 1 - k));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= trial[XW] ? rem_q[k] : trial[XW-1:0];
        q_q[k+1]   <= {q_q[k][QB_W-2:0], ~trial[XW]};
        dv_q[k+1]  <= dv_q[k];
        ng_q[k+1]  <= ng_q[k];
        ov_q[k+1]  <= ov_q[k];
      end
    end
  end

  // negative: magnitude rounds up when anything was dropped
  always_comb begin
    qq = (QB_W+1)'(q_q[QB_W]) + (QB_W+1)'(rem_q[QB_W] != '0);
    if (!ng_q[QB_W]) begin
      if (ov_q[QB_W] || (q_q[QB_W][QB_W-1:OUT_W-1] != '0)) quot_d = SAT_MAX;
      else quot_d = q_q[QB_W][OUT_W-1:0];
    end else begin
      if (ov_q[QB_W] || (qq > NEG_LIM)) quot_d = SAT_MIN;
      else quot_d = '0 - qq[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quot_q <= quot_d;
    end
  end

  assign quot_o = $signed(quot_q);

endmodule

`default_nettype wire

// File: sv/camera_point_projection.sv
// Top level of the camera point projection pipeline.
`timescale 1ns / 1ps
`default_nettype none

// Projects one 3D point per request onto the camera plane. Throughput is one
// point per clock while the output is not stalled. The 33-stage restoring
// divider resolves one quotient bit per stage. The whole pipeline advances
// together: when the output holds a result and out_stall_i is high, every
// stage freezes and in_stall_o rises; bubbles elsewhere do not block intake.
// Config writes are always ready and must only occur while the pipeline is
// empty. Rejected points return the sentinel -10000 (in output fixed point)
// on both coordinates with rejected set. Results are floor-rounded and
// saturated to 32-bit signed.

`include "camera_point_projection_assert.svh"

module camera_point_projection #(
  parameter int FRACTION_BITS = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire cpp_pkg::cpp_point_t               in_data_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output cpp_pkg::cpp_screen_t                   out_data_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [cpp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [cpp_pkg::VEC_W-1:0]         cfg_data_i
);
  import cpp_pkg::*;

  localparam int CW    = CMP_W;
  localparam int FB    = FRACTION_BITS;
  localparam int PNW   = 2*CW + 2;           // P.N, L.N
  localparam int AW_   = 2*CW + 3;           // L.N - P.N
  localparam int NFW   = 2*CW + 1;           // N*f
  localparam int DIRW  = 2*CW + FB + 2;      // F and P-F, 2*FB fraction bits
  localparam int RELW  = CW + 1;             // P-L
  localparam int DNW   = DIRW + CW + 2;      // (P-F).N, F.N, X.(P-F)
  localparam int RXW   = CW + RELW + 2;      // X.(P-L)
  localparam int PRW   = RXW + DNW;          // numerator products
  localparam int NUMW  = PRW + 1;
  localparam int DDW   = DNW + FB;
  localparam int CMPW  = AW_ + FB;
  localparam int NSTG  = 2*MUL_LAT + DIV_LAT + 7;
  localparam logic signed [OUT_W-1:0] SENT_RAW =
    OUT_W'(SENTINEL_VALUE * (2 ** FRACTION_BITS));

  // --------------------------------------------------------------------
  // config registers
  // --------------------------------------------------------------------
  logic [VEC_W-1:0] loc_q, nrm_q, xax_q, yax_q;
  logic [CW-1:0]    focal_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loc_q   <= '0;
      nrm_q   <= '0;
      xax_q   <= '0;
      yax_q   <= '0;
      focal_q <= '0;
    end else if (cfg_valid_i) begin
      case (cpp_cfg_e'(cfg_index_i))
        CFG_LOCATION: loc_q   <= cfg_data_i;
        CFG_NORMAL:   nrm_q   <= cfg_data_i;
        CFG_X_AXIS:   xax_q   <= cfg_data_i;
        CFG_Y_AXIS:   yax_q   <= cfg_data_i;
        CFG_FOCAL:    focal_q <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] loc_c [3], nrm_c [3], xax_c [3], yax_c [3], pin_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      loc_c[i] = loc_q[i*CW +: CW];
      nrm_c[i] = nrm_q[i*CW +: CW];
      xax_c[i] = xax_q[i*CW +: CW];
      yax_c[i] = yax_q[i*CW +: CW];
    end
  end

  // --------------------------------------------------------------------
  // pipeline control: one enable for every stage
  // --------------------------------------------------------------------
  logic            pipe_en;
  logic [NSTG-1:0] v_q;

  assign pipe_en     = !v_q[NSTG-1] || !out_stall_i;
  assign in_stall_o  = !pipe_en;
  assign out_valid_o = v_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (pipe_en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------
  // stage 0: point capture
  // --------------------------------------------------------------------
  cpp_point_t pt_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) pt_q <= in_data_i;
  end

  assign pin_c[0] = pt_q.point_x;
  assign pin_c[1] = pt_q.point_y;
  assign pin_c[2] = pt_q.point_z;

  // --------------------------------------------------------------------
  // stage 1: N*f, P.N and L.N terms, P-L
  // --------------------------------------------------------------------
  logic signed [CW-1:0]   p1_q  [3];
  logic signed [RELW-1:0] rel1_q[3];
  logic signed [NFW-1:0]  nf_q  [3];
  logic signed [2*CW-1:0] pp_q  [3], lp_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        p1_q[i]   <= pin_c[i];
        rel1_q[i] <= RELW'(pin_c[i]) - RELW'(loc_c[i]);
        nf_q[i]   <= NFW'(nrm_c[i]) * $signed({1'b0, focal_q});
        pp_q[i]   <= pin_c[i] * nrm_c[i];
        lp_q[i]   <= loc_c[i] * nrm_c[i];
      end
    end
  end

  // --------------------------------------------------------------------
  // stage 2: F, P-F, dot sums
  // --------------------------------------------------------------------
  logic signed [DIRW-1:0] f2_d [3], f2_q[3], dir_q[3];
  logic signed [RELW-1:0] rel2_q[3];
  logic signed [PNW-1:0]  pn2_q, ln2_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f2_d[i] = (DIRW'(loc_c[i]) <<< FB) + DIRW'(nf_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        f2_q[i]   <= f2_d[i];
        dir_q[i]  <= (DIRW'(p1_q[i]) <<< FB) - f2_d[i];
        rel2_q[i] <= rel1_q[i];
      end
      pn2_q <= PNW'(pp_q[0]) + PNW'(pp_q[1]) + PNW'(pp_q[2]);
      ln2_q <= PNW'(lp_q[0]) + PNW'(lp_q[1]) + PNW'(lp_q[2]);
    end
  end

  // --------------------------------------------------------------------
  // first multiplier bank: per-component products of the dot products
  // --------------------------------------------------------------------
  logic signed [DIRW+CW-1:0] m_dn [3], m_fn[3], m_dx[3], m_dy[3];
  logic signed [RELW+CW-1:0] m_rx [3], m_ry[3];

  for (genvar i = 0; i < 3; i++) begin : g_mul1
    cpp_mul #(.AW(DIRW), .BW(CW)) u_dn (
      .clk_i, .en_i(pipe_en), .a_i(dir_q[i]), .b_i(nrm_c[i]), .p_o(m_dn[i]));
    cpp_mul #(.AW(DIRW), .BW(CW)) u_fn (
      .clk_i, .en_i(pipe_en), .a_i(f2_q[i]), .b_i(nrm_c[i]), .p_o(m_fn[i]));
    cpp_mul #(.AW(DIRW), .BW(CW)) u_dx (
      .clk_i, .en_i(pipe_en), .a_i(dir_q[i]), .b_i(xax_c[i]), .p_o(m_dx[i]));
    cpp_mul #(.AW(DIRW), .BW(CW)) u_dy (
      .clk_i, .en_i(pipe_en), .a_i(dir_q[i]), .b_i(yax_c[i]), .p_o(m_dy[i]));
    cpp_mul #(.AW(RELW), .BW(CW)) u_rx (
      .clk_i, .en_i(pipe_en), .a_i(rel2_q[i]), .b_i(xax_c[i]), .p_o(m_rx[i]));
    cpp_mul #(.AW(RELW), .BW(CW)) u_ry (
      .clk_i, .en_i(pipe_en), .a_i(rel2_q[i]), .b_i(yax_c[i]), .p_o(m_ry[i]));
  end

  // side band alongside the first bank
  logic signed [AW_-1:0] a_dq [MUL_LAT];
  logic signed [PNW-1:0] pn_dq[MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_dq[0]  <= AW_'(ln2_q) - AW_'(pn2_q);
      pn_dq[0] <= pn2_q;
      for (int k = 1; k < MUL_LAT; k++) begin
        a_dq[k]  <= a_dq[k-1];
        pn_dq[k] <= pn_dq[k-1];
      end
    end
  end

  // --------------------------------------------------------------------
  // T1: dot products complete
  // --------------------------------------------------------------------
  logic signed [DNW-1:0] dn_q, fn_q, dx_q, dy_q;
  logic signed [RXW-1:0] rx_q, ry_q;
  logic signed [AW_-1:0] a_q;
  logic signed [PNW-1:0] pn_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dn_q <= DNW'(m_dn[0]) + DNW'(m_dn[1]) + DNW'(m_dn[2]);
      fn_q <= DNW'(m_fn[0]) + DNW'(m_fn[1]) + DNW'(m_fn[2]);
      dx_q <= DNW'(m_dx[0]) + DNW'(m_dx[1]) + DNW'(m_dx[2]);
      dy_q <= DNW'(m_dy[0]) + DNW'(m_dy[1]) + DNW'(m_dy[2]);
      rx_q <= RXW'(m_rx[0]) + RXW'(m_rx[1]) + RXW'(m_rx[2]);
      ry_q <= RXW'(m_ry[0]) + RXW'(m_ry[1]) + RXW'(m_ry[2]);
      a_q  <= a_dq[MUL_LAT-1];
      pn_q <= pn_dq[MUL_LAT-1];
    end
  end

  // visibility tests: opposite signs of F.N and P.N, degenerate ray,
  // or the point lies closer to the plane than the focal length
  logic            fn_pos, fn_neg, pn_pos, pn_neg, rej_t;
  logic [AW_-1:0]  abs_a;
  logic [DNW-1:0]  dmag_t;

  assign fn_neg = fn_q[DNW-1];
  assign fn_pos = !fn_q[DNW-1] && (fn_q != '0);
  assign pn_neg = pn_q[PNW-1];
  assign pn_pos = !pn_q[PNW-1] && (pn_q != '0);
  assign abs_a  = a_q[AW_-1] ? AW_'(-a_q) : AW_'(a_q);
  assign dmag_t = dn_q[DNW-1] ? DNW'(-dn_q) : DNW'(dn_q);
  assign rej_t  = (fn_pos && pn_neg) || (fn_neg && pn_pos) || (dn_q == '0) ||
                  ((CMPW'(focal_q) << FB) > CMPW'(abs_a));

  // --------------------------------------------------------------------
  // second multiplier bank: numerators X.(P-L)*D + (L.N-P.N)*X.(P-F)
  // --------------------------------------------------------------------
  logic signed [PRW-1:0] m_xa, m_xb, m_ya, m_yb;

  cpp_mul #(.AW(RXW), .BW(DNW)) u_xa (
    .clk_i, .en_i(pipe_en), .a_i(rx_q), .b_i(dn_q), .p_o(m_xa));
  cpp_mul #(.AW(AW_), .BW(DNW)) u_xb (
    .clk_i, .en_i(pipe_en), .a_i(a_q), .b_i(dx_q), .p_o(m_xb));
  cpp_mul #(.AW(RXW), .BW(DNW)) u_ya (
    .clk_i, .en_i(pipe_en), .a_i(ry_q), .b_i(dn_q), .p_o(m_ya));
  cpp_mul #(.AW(AW_), .BW(DNW)) u_yb (
    .clk_i, .en_i(pipe_en), .a_i(a_q), .b_i(dy_q), .p_o(m_yb));

  logic           rej_dq  [MUL_LAT];
  logic           dneg_dq [MUL_LAT];
  logic [DNW-1:0] dmag_dq [MUL_LAT];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rej_dq[0]  <= rej_t;
      dneg_dq[0] <= dn_q[DNW-1];
      dmag_dq[0] <= dmag_t;
      for (int k = 1; k < MUL_LAT; k++) begin
        rej_dq[k]  <= rej_dq[k-1];
        dneg_dq[k] <= dneg_dq[k-1];
        dmag_dq[k] <= dmag_dq[k-1];
      end
    end
  end

  // --------------------------------------------------------------------
  // numerator sums, then sign/magnitude for the divider
  // --------------------------------------------------------------------
  logic signed [NUMW-1:0] nx_q, ny_q;
  logic                   rej12_q, dneg12_q;
  logic [DNW-1:0]         dmag12_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      nx_q     <= NUMW'(m_xa) + NUMW'(m_xb);
      ny_q     <= NUMW'(m_ya) + NUMW'(m_yb);
      rej12_q  <= rej_dq[MUL_LAT-1];
      dneg12_q <= dneg_dq[MUL_LAT-1];
      dmag12_q <= dmag_dq[MUL_LAT-1];
    end
  end

  // a negative divisor flips the quotient sign
  logic [NUMW-1:0] magx_q, magy_q;
  logic            sgnx_q, sgny_q, rej13_q;
  logic [DDW-1:0]  dd_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      magx_q  <= nx_q[NUMW-1] ? NUMW'(-nx_q) : NUMW'(nx_q);
      magy_q  <= ny_q[NUMW-1] ? NUMW'(-ny_q) : NUMW'(ny_q);
      sgnx_q  <= nx_q[NUMW-1] ^ dneg12_q;
      sgny_q  <= ny_q[NUMW-1] ^ dneg12_q;
      dd_q    <= DDW'(dmag12_q) << FB;
      rej13_q <= rej12_q;
    end
  end

  // --------------------------------------------------------------------
  // dividers
  // --------------------------------------------------------------------
  logic signed [OUT_W-1:0] qx, qy;

  cpp_div #(.NW(NUMW), .DW(DDW)) u_div_x (
    .clk_i, .en_i(pipe_en), .mag_i(magx_q), .div_i(dd_q), .neg_i(sgnx_q), .quot_o(qx));
  cpp_div #(.NW(NUMW), .DW(DDW)) u_div_y (
    .clk_i, .en_i(pipe_en), .mag_i(magy_q), .div_i(dd_q), .neg_i(sgny_q), .quot_o(qy));

  logic rej_div_q [DIV_LAT];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      rej_div_q[0] <= rej13_q;
      for (int k = 1; k < DIV_LAT; k++) rej_div_q[k] <= rej_div_q[k-1];
    end
  end

  // --------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------
  cpp_screen_t out_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_q.rejected <= rej_div_q[DIV_LAT-1];
      out_q.screen_x <= rej_div_q[DIV_LAT-1] ? SENT_RAW : qx;
      out_q.screen_y <= rej_div_q[DIV_LAT-1] ? SENT_RAW : qy;
    end
  end

  assign out_data_o = out_q;

  // --------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------
  `CPP_ASSERT_IMPL(a_rej_sentinel, out_valid_o && out_data_o.rejected,
    (out_data_o.screen_x == SENT_RAW) && (out_data_o.screen_y == SENT_RAW))
  `CPP_ASSERT_NEXT(a_stall_freeze, v_q[NSTG-1] && out_stall_i, $stable(v_q))
  `CPP_ASSERT_NEXT(a_accept_enters, in_valid_i && !in_stall_o, v_q[0])

endmodule

`default_nettype wire
